// File: src/insertion_sorter_assert.svh
// Assertion macros for the insertion sorter.
`ifndef INSERTION_SORTER_ASSERT_SVH
`define INSERTION_SORTER_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, gated by the active-low reset
`define ISORT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication, gated by the active-low reset
`define ISORT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ISORT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ISORT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: src/isort_pkg.sv
package isort_pkg;

	localparam int unsigned ValueW = 32;

	// input beat
	typedef struct packed {
		logic signed [ValueW-1:0] value;
		logic                     last;
	} isort_in_t;

	// result beat
	typedef struct packed {
		logic signed [ValueW-1:0] sorted_value;
		logic                     final_res;
	} isort_out_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_PLACE,
		ST_EMIT
	} isort_state_t;

	// source of the store write data
	typedef enum logic [1:0] {
		WSEL_ITEM,
		WSEL_HELD,
		WSEL_SHIFT
	} isort_wsel_t;

	// controller to datapath
	typedef struct packed {
		logic        we;
		logic        rd_en;
		isort_wsel_t wsel;
		logic        emit_valid;
		logic        emit_final;
	} isort_ctl_t;

endpackage

// File: src/isort_ram.sv
module isort_ram import isort_pkg::*; #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/isort_ctrl.sv
module isort_ctrl import isort_pkg::*; #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     last_in,
	input  logic                     gt,
	output logic                     busy,
	output isort_ctl_t               ctl,
	output logic [$clog2(DEPTH)-1:0] waddr,
	output logic [$clog2(DEPTH)-1:0] raddr
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	isort_state_t  state_q, state_d;
	logic [AW-1:0] pos_q;
	logic [AW-1:0] k_q;
	logic [CW-1:0] count_q;
	logic          last_q;
	logic          accept;
	logic [CW-1:0] count_inc;
	logic          set_end;
	logic          emit_done;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && (state_q == ST_IDLE);
	assign count_inc = count_q + CW'(1);
	assign set_end   = last_q || (count_inc == CW'(DEPTH));
	assign emit_done = ((CW'(k_q) + CW'(1)) == count_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (count_q == '0) begin
						state_d = (last_in || (count_inc == CW'(DEPTH))) ? ST_EMIT : ST_IDLE;
					end else begin
						state_d = ST_SHIFT;
					end
				end
			end
			ST_SHIFT: begin
				if (gt) begin
					state_d = (pos_q == AW'(1)) ? ST_PLACE : ST_SHIFT;
				end else begin
					state_d = set_end ? ST_EMIT : ST_IDLE;
				end
			end
			ST_PLACE: begin
				state_d = set_end ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				state_d = emit_done ? ST_IDLE : ST_EMIT;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// store and emit controls
	always_comb begin
		ctl   = '{we: 1'b0, rd_en: 1'b0, wsel: WSEL_HELD, emit_valid: 1'b0, emit_final: 1'b0};
		waddr = pos_q;
		raddr = pos_q - AW'(1);
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (count_q == '0) begin
						ctl.we   = 1'b1;
						ctl.wsel = WSEL_ITEM;
						waddr    = '0;
					end else begin
						ctl.rd_en = 1'b1;
						raddr     = count_q[AW-1:0] - AW'(1);
					end
				end
			end
			ST_SHIFT: begin
				ctl.we = 1'b1;
				if (gt) begin
					ctl.wsel = WSEL_SHIFT;
					// fetch the next lower neighbor while this one moves up
					if (pos_q != AW'(1)) begin
						ctl.rd_en = 1'b1;
						raddr     = pos_q - AW'(2);
					end
				end
			end
			ST_PLACE: begin
				ctl.we = 1'b1;
			end
			ST_EMIT: begin
				ctl.rd_en      = 1'b1;
				raddr          = k_q;
				ctl.emit_valid = 1'b1;
				ctl.emit_final = emit_done;
			end
			default: begin
				ctl.we = 1'b0;
			end
		endcase
	end

	// advance state, position, count and emit index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			k_q     <= '0;
			count_q <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= last_in;
						pos_q  <= count_q[AW-1:0];
						if (count_q == '0) begin
							count_q <= count_inc;
							k_q     <= '0;
						end
					end
				end
				ST_SHIFT: begin
					if (gt) begin
						pos_q <= pos_q - AW'(1);
					end else begin
						count_q <= count_inc;
						k_q     <= '0;
					end
				end
				ST_PLACE: begin
					count_q <= count_inc;
					k_q     <= '0;
				end
				ST_EMIT: begin
					k_q <= k_q + AW'(1);
					if (emit_done) begin
						count_q <= '0;
					end
				end
				default: begin
					count_q <= '0;
				end
			endcase
		end
	end

endmodule

// File: src/insertion_sorter.sv
// Insertion sorter for sets of signed 32-bit values.
// Input: drive item (value, last) with start; the beat is taken on a rising
// edge with start high and busy low. A set ends on a beat with last set, or on
// the beat that fills the store of DEPTH entries.
// Insertion: a beat into an empty store is written in its accepting cycle and
// busy stays low unless the beat ends the set. Otherwise the stored elements
// are walked from the top, one store read and one write per cycle, and busy
// stays high from the accepting edge until the beat is written above the first
// element not larger than it, or at the bottom. The single read port of the
// store sets this pace.
// Output: once a set ends, busy stays high while the whole set is read out
// smallest first, one result per cycle on result with strobe high for one
// cycle; final_res marks the largest. Each result is the registered store read
// of an emit state, the first emit state follows the ending beat's last
// insertion cycle, and the last result shares its cycle with the earliest next
// accept. The receiver cannot stall; results are not held.
// Reset: asynchronous, active low; the store is left as is, the element
// count clears and the block comes up idle.
module insertion_sorter import isort_pkg::*; #(
	parameter int unsigned DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  isort_in_t  item,
	output logic       busy,
	output logic       strobe,
	output isort_out_t result
);

	`include "insertion_sorter_assert.svh"

	localparam int unsigned AW = $clog2(DEPTH);

	isort_ctl_t               ctl;
	logic [AW-1:0]            waddr;
	logic [AW-1:0]            raddr;
	logic [ValueW-1:0]        rdata;
	logic [ValueW-1:0]        wdata;
	logic signed [ValueW-1:0] value_q;
	logic                     gt;
	logic                     valid_s1;
	logic                     final_s1;

	isort_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last_in(item.last),
		.gt     (gt),
		.busy   (busy),
		.ctl    (ctl),
		.waddr  (waddr),
		.raddr  (raddr)
	);

	isort_ram #(
		.WIDTH(ValueW),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ctl.we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (ctl.rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	// hold the element being inserted
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			value_q <= item.value;
		end
	end

	// stored neighbor strictly above the new element moves up
	assign gt = ($signed(rdata) > value_q);

	// pick the write data
	always_comb begin
		case (ctl.wsel)
			WSEL_ITEM:  wdata = item.value;
			WSEL_SHIFT: wdata = rdata;
			WSEL_HELD:  wdata = value_q;
			default:    wdata = value_q;
		endcase
	end

	// align emit marks with the store read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			final_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctl.emit_valid;
			final_s1 <= ctl.emit_final;
		end
	end

	assign strobe              = valid_s1;
	assign result.sorted_value = rdata;
	assign result.final_res    = final_s1;

	`ISORT_ASSERT_NXT(a_final_ends_burst, clk, arst_n, strobe && final_s1, !strobe)
	`ISORT_ASSERT_NXT(a_burst_contiguous, clk, arst_n, strobe && !final_s1, strobe)
	`ISORT_ASSERT_IMP(a_no_rw_collision, clk, arst_n, ctl.we && ctl.rd_en, waddr != raddr)

endmodule
